>>> src/matrix_row_shift_and_rotate_core_macros.svh
// Assertion helpers for the top-level RTL file.
`ifndef MATRIX_ROW_SHIFT_AND_ROTATE_CORE_MACROS_SVH
`define MATRIX_ROW_SHIFT_AND_ROTATE_CORE_MACROS_SVH

// Checked on every rising edge of clock, quiet while reset is high.
`define MRSR_ASSERT(label, prop) \
   label: assert property (@(posedge clock) disable iff (reset) prop) \
      else $error("%m: check failed");

// Checked on every rising edge of clock, reset included.
`define MRSR_ASSERT_ALWAYS(label, prop) \
   label: assert property (@(posedge clock) prop) \
      else $error("%m: check failed");

`endif

>>> src/mrsr_pkg.sv
package mrsr_pkg;

   // Largest grid supported by default
   localparam int MAX_SIZE_DEF = 8;

   // Field widths
   localparam int DATA_W  = 32;
   localparam int INDEX_W = 3;
   localparam int SIZE_W  = 4;
   localparam int MODE_W  = 2;

   // Compare width: holds any size or index up to 16
   localparam int CMP_W = 5;

   // Register file
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;
   localparam logic [SIZE_W-1:0] ACTIVE_SIZE_RST = 4'd8;
   localparam logic [CSR_ADDR_W-3:0] REG_ACTIVE_SIZE = 1'b0;

   typedef enum logic [MODE_W-1:0] {
      MODE_WRITE   = 2'd0,
      MODE_ROT_ROW = 2'd1,
      MODE_ROT_MAT = 2'd2,
      MODE_READ    = 2'd3
   } mode_type;

   // Operation handed to the matrix array for execution
   typedef struct packed {
      logic                en;
      mode_type            mode;
      logic [INDEX_W-1:0]  row;
      logic [INDEX_W-1:0]  col;
      logic [DATA_W-1:0]   value;
   } mrsr_cmd_type;

endpackage

>>> src/mrsr_csr.sv
module mrsr_csr (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  csr_psel,
   input  logic                                  csr_penable,
   input  logic                                  csr_pwrite,
   input  logic [mrsr_pkg::CSR_ADDR_W-1:0]       csr_paddr,
   input  logic [mrsr_pkg::CSR_DATA_W-1:0]       csr_pwdata,
   output logic [mrsr_pkg::CSR_DATA_W-1:0]       csr_prdata,
   output logic                                  csr_pready,
   output logic [mrsr_pkg::SIZE_W-1:0]           active_size
);

   logic [mrsr_pkg::SIZE_W-1:0]       active_size_ff;
   logic [mrsr_pkg::SIZE_W-1:0]       active_size_in;
   logic [mrsr_pkg::CSR_ADDR_W-3:0]   reg_sel;
   logic                              wr_en;

   // Word select; byte offset bits are ignored
   assign reg_sel    = csr_paddr[mrsr_pkg::CSR_ADDR_W-1:2];
   assign wr_en      = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_pready = 1'b1;

   // Register write
   always_comb begin
      active_size_in = active_size_ff;
      if (wr_en && (reg_sel == mrsr_pkg::REG_ACTIVE_SIZE)) begin
         active_size_in = csr_pwdata[mrsr_pkg::SIZE_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_size_ff <= mrsr_pkg::ACTIVE_SIZE_RST;
      end else begin
         active_size_ff <= active_size_in;
      end
   end

   // Read back
   always_comb begin
      csr_prdata = '0;
      if (reg_sel == mrsr_pkg::REG_ACTIVE_SIZE) begin
         csr_prdata = {{(mrsr_pkg::CSR_DATA_W - mrsr_pkg::SIZE_W){1'b0}}, active_size_ff};
      end
   end

   assign active_size = active_size_ff;

endmodule

>>> src/mrsr_array.sv
module mrsr_array #(
   parameter int MAX_SIZE = mrsr_pkg::MAX_SIZE_DEF
) (
   input  logic                               clock,
   input  mrsr_pkg::mrsr_cmd_type             cmd,
   input  logic [mrsr_pkg::SIZE_W-1:0]        active_size,
   output logic [mrsr_pkg::DATA_W-1:0]        rd_data
);

   localparam int CW = mrsr_pkg::CMP_W;

   // Element (r, c) lives in mat_ff[r][c]; no reset, contents undefined until written
   logic [mrsr_pkg::DATA_W-1:0] mat_ff   [MAX_SIZE][MAX_SIZE];
   logic [mrsr_pkg::DATA_W-1:0] mat_in   [MAX_SIZE][MAX_SIZE];
   logic [mrsr_pkg::DATA_W-1:0] last_elem [MAX_SIZE];
   logic [mrsr_pkg::DATA_W-1:0] rot_src  [MAX_SIZE][MAX_SIZE];
   logic [CW-1:0]               eff_n;
   logic [CW-1:0]               row_x;
   logic [CW-1:0]               col_x;
   logic                        row_ok;
   logic                        col_ok;

   // Active size saturates at the grid size
   assign eff_n  = (CW'(active_size) > CW'(MAX_SIZE)) ? CW'(MAX_SIZE) : CW'(active_size);
   assign row_x  = CW'(cmd.row);
   assign col_x  = CW'(cmd.col);
   assign row_ok = row_x < eff_n;
   assign col_ok = col_x < eff_n;

   // Last active element of each row, wraps to column 0 on a row rotation
   always_comb begin
      for (int r = 0; r < MAX_SIZE; r++) begin
         last_elem[r] = '0;
         for (int k = 0; k < MAX_SIZE; k++) begin
            if (CW'(k) + CW'(1) == eff_n) begin
               last_elem[r] = mat_ff[r][k];
            end
         end
      end
   end

   // Clockwise rotation: new[r][c] = old[n-1-c][r]
   always_comb begin
      for (int r = 0; r < MAX_SIZE; r++) begin
         for (int c = 0; c < MAX_SIZE; c++) begin
            rot_src[r][c] = mat_ff[r][c];
            for (int k = 0; k < MAX_SIZE; k++) begin
               if (CW'(k) + CW'(c) + CW'(1) == eff_n) begin
                  rot_src[r][c] = mat_ff[k][r];
               end
            end
         end
      end
   end

   // Next matrix contents
   always_comb begin
      for (int r = 0; r < MAX_SIZE; r++) begin
         for (int c = 0; c < MAX_SIZE; c++) begin
            mat_in[r][c] = mat_ff[r][c];
            case (cmd.mode)
               mrsr_pkg::MODE_WRITE: begin
                  if (row_ok && col_ok && (CW'(r) == row_x) && (CW'(c) == col_x)) begin
                     mat_in[r][c] = cmd.value;
                  end
               end
               mrsr_pkg::MODE_ROT_ROW: begin
                  if (row_ok && (CW'(r) == row_x) && (CW'(c) < eff_n)) begin
                     if (c == 0) begin
                        mat_in[r][c] = last_elem[r];
                     end else begin
                        mat_in[r][c] = mat_ff[r][(c + MAX_SIZE - 1) % MAX_SIZE];
                     end
                  end
               end
               mrsr_pkg::MODE_ROT_MAT: begin
                  if ((CW'(r) < eff_n) && (CW'(c) < eff_n)) begin
                     mat_in[r][c] = rot_src[r][c];
                  end
               end
               default: begin
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.en) begin
         mat_ff <= mat_in;
      end
   end

   // Element read, zero outside the active part
   always_comb begin
      rd_data = '0;
      for (int r = 0; r < MAX_SIZE; r++) begin
         for (int c = 0; c < MAX_SIZE; c++) begin
            if (row_ok && col_ok && (CW'(r) == row_x) && (CW'(c) == col_x)) begin
               rd_data = mat_ff[r][c];
            end
         end
      end
   end

endmodule

>>> src/matrix_row_shift_and_rotate_core.sv
// Square matrix of signed 32-bit elements with row and whole-matrix rotation.
// Request channel (req_*): valid/ready; each request is a write, a right
// rotation of one row, a clockwise rotation of the active matrix, or a read.
// Response channel (rsp_*): valid/ready; only a read request gives a response,
// in request order, with zero for a position outside the active size.
// Register port (csr_*): APB-style, pready always high; active_size at 0x0,
// to be written only while no request is in flight.
// Flow: a request is registered in the input register at acceptance and
// executed from there by the execute stage; a read result is registered in
// the response register when the read executes.
// Throughput: one request per cycle unless a read waits on the response
// side; the single execute stage rewrites the register matrix per request.
// Stall: the response register holds its data while rsp_ready is low; a
// read waiting in the execute stage then holds, and req_ready drops. Writes
// and rotations in the execute stage never wait on the response side.
// Reset: clears the pipeline valids and sets active_size to 8; the matrix
// contents are not cleared and are undefined until written.
`include "matrix_row_shift_and_rotate_core_macros.svh"

module matrix_row_shift_and_rotate_core #(
   parameter int MAX_SIZE = mrsr_pkg::MAX_SIZE_DEF
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_ready,
   input  logic [mrsr_pkg::MODE_W-1:0]            req_mode,
   input  logic [mrsr_pkg::INDEX_W-1:0]           req_row_index,
   input  logic [mrsr_pkg::INDEX_W-1:0]           req_column_index,
   input  logic signed [mrsr_pkg::DATA_W-1:0]     req_element_value,
   output logic                                   rsp_valid,
   input  logic                                   rsp_ready,
   output logic signed [mrsr_pkg::DATA_W-1:0]     rsp_read_value,
   input  logic                                   csr_psel,
   input  logic                                   csr_penable,
   input  logic                                   csr_pwrite,
   input  logic [mrsr_pkg::CSR_ADDR_W-1:0]        csr_paddr,
   input  logic [mrsr_pkg::CSR_DATA_W-1:0]        csr_pwdata,
   output logic [mrsr_pkg::CSR_DATA_W-1:0]        csr_prdata,
   output logic                                   csr_pready
);

   logic                              s1_valid_ff;
   logic                              s1_valid_in;
   mrsr_pkg::mrsr_cmd_type            s1_cmd_ff;
   mrsr_pkg::mrsr_cmd_type            s1_cmd_in;
   mrsr_pkg::mrsr_cmd_type            exec_cmd;
   logic                              rsp_valid_ff;
   logic                              rsp_valid_in;
   logic [mrsr_pkg::DATA_W-1:0]       rsp_data_ff;
   logic [mrsr_pkg::DATA_W-1:0]       rsp_data_in;
   logic [mrsr_pkg::DATA_W-1:0]       rd_data;
   logic [mrsr_pkg::SIZE_W-1:0]       active_size;
   logic                              s1_is_read;
   logic                              exec_go;
   logic                              req_take;

   mrsr_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .active_size (active_size)
   );

   // Execute stage control: a read needs room in the response register
   assign s1_is_read = (s1_cmd_ff.mode == mrsr_pkg::MODE_READ);
   assign exec_go    = s1_valid_ff && (!s1_is_read || !rsp_valid_ff || rsp_ready);
   assign req_ready  = !s1_valid_ff || exec_go;
   assign req_take   = req_valid && req_ready;

   always_comb begin
      exec_cmd    = s1_cmd_ff;
      exec_cmd.en = exec_go;
   end

   mrsr_array #(
      .MAX_SIZE (MAX_SIZE)
   ) u_array (
      .clock       (clock),
      .cmd         (exec_cmd),
      .active_size (active_size),
      .rd_data     (rd_data)
   );

   // Input register
   always_comb begin
      s1_valid_in = s1_valid_ff;
      s1_cmd_in   = s1_cmd_ff;
      if (req_take) begin
         s1_valid_in     = 1'b1;
         s1_cmd_in.en    = 1'b1;
         s1_cmd_in.mode  = mrsr_pkg::mode_type'(req_mode);
         s1_cmd_in.row   = req_row_index;
         s1_cmd_in.col   = req_column_index;
         s1_cmd_in.value = req_element_value;
      end else if (exec_go) begin
         s1_valid_in = 1'b0;
      end
   end

   // Response register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (exec_go && s1_is_read) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = rd_data;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      s1_cmd_ff   <= s1_cmd_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_read_value = $signed(rsp_data_ff);

   // Checks
   `MRSR_ASSERT(a_read_needs_room, exec_go && s1_is_read |-> !rsp_valid_ff || rsp_ready)
   `MRSR_ASSERT(a_rsp_from_read, $rose(rsp_valid_ff) |-> $past(exec_go && s1_is_read))
   `MRSR_ASSERT(a_stall_only_on_read, !req_ready |-> s1_is_read && rsp_valid_ff && !rsp_ready)
   `MRSR_ASSERT_ALWAYS(a_reset_empty, $past(reset) |-> !rsp_valid_ff && !s1_valid_ff)

endmodule
